[design/tva_pkg.sv]
// Shared types and constants for the vertex tangent accumulator.
package tva_pkg;

  localparam int IDX_W  = 10;
  localparam int POS_W  = 24;
  localparam int UV_W   = 20;
  localparam int TAN_W  = 32;
  localparam int SUM_W  = 40;
  localparam int DVD_W  = 64;
  localparam int DSR_W  = 44;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic signed [UV_W-1:0]  u;
    logic signed [UV_W-1:0]  v;
  } vtx_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

[design/tva_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module tva_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tva_pkg::div_req_t req_i,
  output tva_pkg::div_rsp_t rsp_o
);

  localparam int DW = tva_pkg::DVD_W;
  localparam int RW = tva_pkg::DSR_W;

  logic            busy_q;
  logic            done_q;
  logic [5:0]      cnt_q;
  logic [DW-1:0]   dvd_q;
  logic [RW-1:0]   rem_q;
  logic [RW-1:0]   dsr_q;
  logic [RW:0]     rem_sh;
  logic [RW+1:0]   diff;
  logic            ge;

  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign ge     = ~diff[RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the dividend register as it empties
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
      dvd_q <= {dvd_q[DW-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

[design/vertex_tangent_accumulator_unit.sv]
// Top level: per-vertex tangent accumulation over vertex and accumulator memories.
//
// Usage: present an item on the input ports with start_i high; it is taken at
// a clock edge where busy_o is low. Opcode load writes a vertex slot and clears
// its tangent sum and share count; it produces no result and busy_o stays low,
// so loads can follow each other on every cycle.
// A triangle item reads its three corners, forms the face tangent and adds it
// into each corner's accumulator (read-modify-write, one corner at a time).
// A read item returns the accumulated tangent divided by the share count.
// Triangle and read items each give one result: done_o is high for exactly one
// cycle with the result ports valid; the receiver cannot stall, so the result
// is simply transferred in that cycle.
// The shared bit-serial divider sets the latency: 64 quotient bits per component,
// three components per item. A triangle skips it when the UV determinant is zero
// and a read when the share count is zero or the slot is beyond the depth;
// triangle corners beyond the depth are not accumulated. Memory reads are registered.
// One item is in flight at a time; busy_o falls in the cycle done_o is high.
// Reset clears the control state only; vertex slots must be loaded before use.
module vertex_tangent_accumulator_unit #(
  parameter int VERTEX_DEPTH = 1024,
  parameter int COUNT_BITS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          opcode_i,
  input  logic [tva_pkg::IDX_W-1:0]           vertex_index_i,
  input  logic signed [tva_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [tva_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [tva_pkg::POS_W-1:0]    pos_z_i,
  input  logic signed [tva_pkg::UV_W-1:0]     tex_u_i,
  input  logic signed [tva_pkg::UV_W-1:0]     tex_v_i,
  input  logic [tva_pkg::IDX_W-1:0]           corner_a_i,
  input  logic [tva_pkg::IDX_W-1:0]           corner_b_i,
  input  logic [tva_pkg::IDX_W-1:0]           corner_c_i,
  output logic                                done_o,
  output logic                                result_kind_o,
  output logic signed [tva_pkg::TAN_W-1:0]    tangent_x_o,
  output logic signed [tva_pkg::TAN_W-1:0]    tangent_y_o,
  output logic signed [tva_pkg::TAN_W-1:0]    tangent_z_o,
  output logic                                degenerate_o,
  output logic                                unreferenced_o,
  output logic                                saturated_o
);

  localparam int AW   = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int SW   = tva_pkg::SUM_W;
  localparam int TW   = tva_pkg::TAN_W;
  localparam int IW   = tva_pkg::IDX_W;
  localparam int ACCW = 3 * SW + COUNT_BITS;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_VRD  = 13'b0000000000010,
    S_UV   = 13'b0000000000100,
    S_DETM = 13'b0000000001000,
    S_DETS = 13'b0000000010000,
    S_NUMM = 13'b0000000100000,
    S_NUMS = 13'b0000001000000,
    S_DIV  = 13'b0000010000000,
    S_ACR  = 13'b0000100000000,
    S_ACW  = 13'b0001000000000,
    S_RDR  = 13'b0010000000000,
    S_RDW  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_e;

  // ---------------------------------------------------------------- helpers
  function automatic logic in_range(logic [IW-1:0] i);
    return 32'(i) < 32'(VERTEX_DEPTH);
  endfunction

  function automatic logic signed [tva_pkg::POS_W-1:0] vcomp(tva_pkg::vtx_t v,
                                                            logic [1:0] k);
    logic signed [tva_pkg::POS_W-1:0] r;
    unique case (k)
      2'd0:    r = v.px;
      2'd1:    r = v.py;
      default: r = v.pz;
    endcase
    return r;
  endfunction

  function automatic logic signed [SW-1:0] acc_sum(logic [ACCW-1:0] a, logic [1:0] k);
    logic signed [SW-1:0] r;
    unique case (k)
      2'd0:    r = a[COUNT_BITS +: SW];
      2'd1:    r = a[COUNT_BITS + SW +: SW];
      default: r = a[COUNT_BITS + 2*SW +: SW];
    endcase
    return r;
  endfunction

  // {sat, value}: quotient magnitude with sign applied, clipped to 32 bits
  function automatic logic [TW:0] clip_q(logic [tva_pkg::DVD_W-1:0] q, logic neg);
    logic [TW:0] r;
    if (!neg) begin
      if (q > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else                   r = {1'b0, q[TW-1:0]};
    end else begin
      if (q > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else                   r = {1'b0, ~q[TW-1:0] + 32'd1};
    end
    return r;
  endfunction

  // {sat, sum}: signed 40-bit add with clipping
  function automatic logic [SW:0] sum_add(logic signed [SW-1:0] s,
                                          logic signed [TW-1:0] t);
    logic signed [SW:0] r;
    logic [SW:0] o;
    r = (SW+1)'(s) + (SW+1)'(t);
    if (!r[SW] && r[SW-1])      o = {1'b1, 1'b0, {(SW-1){1'b1}}};
    else if (r[SW] && !r[SW-1]) o = {1'b1, 1'b1, {(SW-1){1'b0}}};
    else                        o = {1'b0, r[SW-1:0]};
    return o;
  endfunction

  // --------------------------------------------------------------- registers
  state_e                   state_q, state_d;
  logic [1:0]               k_q, k_d;
  logic                     done_q;

  logic [1:0]               op_q;
  logic [IW-1:0]            idx_q;
  logic [IW-1:0]            corner_q [3];
  tva_pkg::vtx_t            vtx_q [3];
  logic signed [20:0]       du1_q, dv1_q, du2_q, dv2_q;
  logic signed [41:0]       p1_q, p2_q;
  logic signed [42:0]       den_q;
  logic signed [45:0]       m1_q, m2_q;
  logic                     neg_q;
  logic [TW-1:0]            t_q [3];
  logic [ACCW-1:0]          acc_q;
  logic                     sat_q, degen_q, unref_q;

  logic                     out_kind_q, out_degen_q, out_unref_q, out_sat_q;
  logic [TW-1:0]            out_t_q [3];

  // memories
  tva_pkg::vtx_t            vmem [VERTEX_DEPTH];
  logic [ACCW-1:0]          amem [VERTEX_DEPTH];
  tva_pkg::vtx_t            vmem_rd_q;
  logic [ACCW-1:0]          amem_rd_q;
  logic                     vmem_we, amem_we;
  logic [AW-1:0]            vmem_wa, vmem_ra, amem_wa, amem_ra;
  tva_pkg::vtx_t            vmem_wd;
  logic [ACCW-1:0]          amem_wd;

  // ------------------------------------------------------------- datapath
  logic                     accept;
  logic [IW-1:0]            corner_k;
  logic signed [24:0]       e1, e2;
  logic signed [46:0]       num;
  logic [46:0]              num_mag;
  logic [42:0]              den_mag;
  logic signed [SW-1:0]     avg_sum;
  logic [SW-1:0]            avg_mag;
  logic [ACCW-1:0]          acc_new;
  logic                     acc_sat;
  logic                     cnt_full;
  logic [TW:0]              clip_r;
  tva_pkg::div_req_t        div_req;
  tva_pkg::div_rsp_t        div_rsp;

  assign accept = start_i && state_q == S_IDLE;
  assign busy_o = state_q != S_IDLE;

  always_comb begin
    unique case (k_q)
      2'd0:    corner_k = corner_q[0];
      2'd1:    corner_k = corner_q[1];
      default: corner_k = corner_q[2];
    endcase
  end

  assign e1      = 25'(vcomp(vtx_q[1], k_q)) - 25'(vcomp(vtx_q[0], k_q));
  assign e2      = 25'(vcomp(vtx_q[2], k_q)) - 25'(vcomp(vtx_q[0], k_q));
  assign num     = 47'(m1_q) - 47'(m2_q);
  assign num_mag = num[46] ? 47'(-num) : 47'(num);
  assign den_mag = den_q[42] ? 43'(-den_q) : 43'(den_q);
  assign avg_sum = acc_sum(acc_q, k_q);
  assign avg_mag = avg_sum[SW-1] ? SW'(-avg_sum) : SW'(avg_sum);
  assign cnt_full = &amem_rd_q[COUNT_BITS-1:0];
  assign clip_r  = clip_q(div_rsp.quotient, neg_q);

  // accumulator update for the corner just read
  always_comb begin
    logic [SW:0] r [3];
    for (int i = 0; i < 3; i++) begin
      r[i] = sum_add(acc_sum(amem_rd_q, 2'(i)), t_q[i]);
    end
    acc_sat = r[0][SW] | r[1][SW] | r[2][SW];
    acc_new = {r[2][SW-1:0], r[1][SW-1:0], r[0][SW-1:0],
               amem_rd_q[COUNT_BITS-1:0] + COUNT_BITS'(1)};
  end

  always_comb begin
    div_req          = '0;
    div_req.dividend = 64'({num_mag, 16'h0000});
    div_req.divisor  = 44'(den_mag);
    if (state_q == S_NUMS) begin
      div_req.start = 1'b1;
    end else if (state_q == S_RDW) begin
      div_req.start = 1'b0;
    end
    if (op_q == tva_pkg::OP_READ) begin
      div_req.dividend = 64'(avg_mag);
      div_req.divisor  = 44'(acc_q[COUNT_BITS-1:0]);
    end
    // averaging launches share the triangle launch state
    if (state_q == S_NUMS && op_q == tva_pkg::OP_READ) div_req.start = 1'b1;
  end

  tva_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // memory port control
  always_comb begin
    vmem_we = accept && opcode_i == tva_pkg::OP_LOAD && in_range(vertex_index_i);
    vmem_wa = AW'(vertex_index_i);
    vmem_wd = '{px: pos_x_i, py: pos_y_i, pz: pos_z_i, u: tex_u_i, v: tex_v_i};
    vmem_ra = AW'(corner_k);
    amem_ra = (state_q == S_RDR) ? AW'(idx_q) : AW'(corner_k);
    if (state_q == S_ACW && !cnt_full) begin
      amem_we = 1'b1;
      amem_wa = AW'(corner_k);
      amem_wd = acc_new;
    end else begin
      amem_we = vmem_we;       // load clears sum and count
      amem_wa = AW'(vertex_index_i);
      amem_wd = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) vmem[vmem_wa] <= vmem_wd;
    vmem_rd_q <= vmem[vmem_ra];
  end

  always_ff @(posedge clk_i) begin
    if (amem_we) amem[amem_wa] <= amem_wd;
    amem_rd_q <= amem[amem_ra];
  end

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    unique case (state_q)
      S_IDLE: begin
        k_d = 2'd0;
        if (accept && opcode_i == tva_pkg::OP_TRI)  state_d = S_VRD;
        if (accept && opcode_i == tva_pkg::OP_READ) state_d = S_RDR;
      end
      S_VRD: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) state_d = S_UV;
      end
      S_UV:   state_d = S_DETM;
      S_DETM: state_d = S_DETS;
      S_DETS: begin
        state_d = S_NUMM;
        k_d     = 2'd0;
      end
      S_NUMM: begin
        if (den_q == '0) begin
          state_d = S_ACR;
          k_d     = 2'd0;
        end else begin
          state_d = S_NUMS;
        end
      end
      S_NUMS: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          if (k_q == 2'd2) begin
            state_d = (op_q == tva_pkg::OP_READ) ? S_FIN : S_ACR;
            k_d     = 2'd0;
          end else begin
            k_d     = k_q + 2'd1;
            state_d = (op_q == tva_pkg::OP_READ) ? S_NUMS : S_NUMM;
          end
        end
      end
      S_ACR: begin
        if (in_range(corner_k)) begin
          state_d = S_ACW;
        end else if (k_q == 2'd2) begin
          state_d = S_FIN;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_ACW: begin
        k_d     = k_q + 2'd1;
        state_d = (k_q == 2'd2) ? S_FIN : S_ACR;
      end
      S_RDR:  state_d = in_range(idx_q) ? S_RDW : S_FIN;
      S_RDW: begin
        k_d     = 2'd0;
        state_d = (amem_rd_q[COUNT_BITS-1:0] == '0) ? S_FIN : S_NUMS;
      end
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      done_q  <= state_q == S_FIN;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_q        <= opcode_i;
          idx_q       <= vertex_index_i;
          corner_q[0] <= corner_a_i;
          corner_q[1] <= corner_b_i;
          corner_q[2] <= corner_c_i;
          sat_q       <= 1'b0;
          degen_q     <= 1'b0;
          unref_q     <= 1'b0;
          for (int i = 0; i < 3; i++) t_q[i] <= '0;
        end
      end
      S_VRD: begin
        // data for the corner addressed in the previous cycle; missing slot reads zero
        if (k_q != 2'd0) begin
          vtx_q[k_q - 2'd1] <= in_range(corner_q[k_q - 2'd1]) ? vmem_rd_q : '0;
        end
      end
      S_UV: begin
        du1_q <= 21'(vtx_q[1].u) - 21'(vtx_q[0].u);
        dv1_q <= 21'(vtx_q[1].v) - 21'(vtx_q[0].v);
        du2_q <= 21'(vtx_q[2].u) - 21'(vtx_q[0].u);
        dv2_q <= 21'(vtx_q[2].v) - 21'(vtx_q[0].v);
      end
      S_DETM: begin
        p1_q <= du1_q * dv2_q;
        p2_q <= du2_q * dv1_q;
      end
      S_DETS: den_q <= 43'(p1_q) - 43'(p2_q);
      S_NUMM: begin
        if (den_q == '0) degen_q <= 1'b1;
        m1_q <= e1 * dv2_q;
        m2_q <= e2 * dv1_q;
      end
      S_NUMS: begin
        neg_q <= (op_q == tva_pkg::OP_READ) ? avg_sum[SW-1] : (num[46] ^ den_q[42]);
      end
      S_DIV: begin
        if (div_rsp.done) begin
          t_q[k_q] <= clip_r[TW-1:0];
          if (clip_r[TW]) sat_q <= 1'b1;
        end
      end
      S_ACW: begin
        if (cnt_full || acc_sat) sat_q <= 1'b1;
      end
      S_RDR: begin
        if (!in_range(idx_q)) unref_q <= 1'b1;
      end
      S_RDW: begin
        acc_q <= amem_rd_q;
        if (amem_rd_q[COUNT_BITS-1:0] == '0) unref_q <= 1'b1;
      end
      S_FIN: begin
        out_kind_q  <= op_q == tva_pkg::OP_READ;
        out_degen_q <= degen_q;
        out_unref_q <= unref_q;
        out_sat_q   <= sat_q;
        for (int i = 0; i < 3; i++) out_t_q[i] <= t_q[i];
      end
      default: ;
    endcase
  end

  assign done_o         = done_q;
  assign result_kind_o  = out_kind_q;
  assign tangent_x_o    = out_t_q[0];
  assign tangent_y_o    = out_t_q[1];
  assign tangent_z_o    = out_t_q[2];
  assign degenerate_o   = out_degen_q;
  assign unreferenced_o = out_unref_q;
  assign saturated_o    = out_sat_q;

endmodule
